// ===== rtl/two_level_inclusive_lru_cache_defines.svh =====
// ---------------------------------------------------------------------------
// two-level inclusive cache assertion macros
// shared property wrappers, clocked on i_clk, quiet during reset
// ---------------------------------------------------------------------------
`ifndef TWO_LEVEL_INCLUSIVE_LRU_CACHE_DEFINES_SVH
`define TWO_LEVEL_INCLUSIVE_LRU_CACHE_DEFINES_SVH

// same-cycle implication
`define TLIC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tlic_pkg.sv =====
// ---------------------------------------------------------------------------
// tlic_pkg
// constants and types of the two-level inclusive cache tag model
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlic_pkg;

    localparam int DEF_L1_LINES  = 64;
    localparam int DEF_L2_LINES  = 1024;
    localparam int DEF_MAX_WAYS  = 8;
    localparam int DEF_ADDR_BITS = 32;

    localparam int SET_W      = 15;
    localparam int WAYS_W     = 4;
    localparam int AGE_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_SETS_LOG2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS_LOG2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_SETS_LOG2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS_LOG2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC  = 3'd5;

    localparam logic [3:0] RST_BLOCK_LOG2   = 4'd2;
    localparam logic [2:0] RST_L1_SETS_LOG2 = 3'd3;
    localparam logic [1:0] RST_L1_WAYS_LOG2 = 2'd1;
    localparam logic [3:0] RST_L2_SETS_LOG2 = 4'd6;
    localparam logic [1:0] RST_L2_WAYS_LOG2 = 2'd2;
    localparam logic       RST_WRITE_ALLOC  = 1'b1;

    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_CLEAR   = 16'h0002,
        S_LAUNCH  = 16'h0004,
        S_MUL     = 16'h0008,
        S_MOD     = 16'h0010,
        S_SCAN_RD = 16'h0020,
        S_SCAN_CK = 16'h0040,
        S_SCAN_END= 16'h0080,
        S_TCH_RD0 = 16'h0100,
        S_TCH_WR0 = 16'h0200,
        S_TCH_RD  = 16'h0400,
        S_TCH_WR  = 16'h0800,
        S_RMW_RD  = 16'h1000,
        S_RMW_WR  = 16'h2000,
        S_NEXT    = 16'h4000,
        S_FIN     = 16'h8000
    } t_state;

    typedef enum logic [19:0] {
        PH_L1_LOOK      = 20'h00001,
        PH_L1_HIT_RMW   = 20'h00002,
        PH_L1_HIT_TCH   = 20'h00004,
        PH_WB_SCAN      = 20'h00008,
        PH_WB_RMW       = 20'h00010,
        PH_WB_TCH       = 20'h00020,
        PH_L1_ALLOC_RMW = 20'h00040,
        PH_L1_ALLOC_TCH = 20'h00080,
        PH_L2_LOOK      = 20'h00100,
        PH_L2_HIT_RMW   = 20'h00200,
        PH_L2_HIT_TCH   = 20'h00400,
        PH_BI_SCAN      = 20'h00800,
        PH_BI_MD_SCAN   = 20'h01000,
        PH_BI_MD_RMW    = 20'h02000,
        PH_BI_MD_TCH    = 20'h04000,
        PH_BI_RMW       = 20'h08000,
        PH_BI_TCH       = 20'h10000,
        PH_L2_ALLOC_RMW = 20'h20000,
        PH_L2_ALLOC_TCH = 20'h40000,
        PH_DONE         = 20'h80000
    } t_phase;

endpackage

// ===== rtl/two_level_inclusive_lru_cache.sv =====
// ---------------------------------------------------------------------------
// two_level_inclusive_lru_cache
// Tag-only inclusive L1/L2 cache with write-back and LRU age counters. Each
// request (read or write of a byte address) returns one result: L1 hit, L2
// hit, dirty L1 victim written into L2, and L2 victim back-invalidating L1.
// Both levels keep {valid, dirty, age, tag} in one synchronous memory each,
// with a write port and a registered read port, walked by one sequencer. A
// request runs as a series of set scans, age updates and single-entry
// updates. A scan or age update starts with the slot base computation (set
// times ways, reciprocal quotient estimate, remainder, one correction), then
// visits each way in turn, an age update having first set the touched entry;
// a single-entry update is a read then a write.
// After reset a clearing pass over max(L1_LINES, L2_LINES) entries runs
// before the first request is taken; configuration writes are taken always.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_level_inclusive_lru_cache_defines.svh"

module two_level_inclusive_lru_cache #(
    parameter int L1_LINES  = tlic_pkg::DEF_L1_LINES,
    parameter int L2_LINES  = tlic_pkg::DEF_L2_LINES,
    parameter int MAX_WAYS  = tlic_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = tlic_pkg::DEF_ADDR_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [ADDR_BITS-1:0]            i_address,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_l1_hit,
    output logic                            o_l2_hit,
    output logic                            o_l1_writeback,
    output logic                            o_l2_back_invalidate,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tlic_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlic_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MAXL  = (L1_LINES > L2_LINES) ? L1_LINES : L2_LINES;
    localparam int RW    = $clog2(2 * MAXL) + 1;
    localparam int IW1   = (L1_LINES > 1) ? $clog2(L1_LINES) : 1;
    localparam int IW2   = (L2_LINES > 1) ? $clog2(L2_LINES) : 1;
    localparam int X_W   = tlic_pkg::SET_W + tlic_pkg::WAYS_W;
    localparam int QW    = X_W + 1;
    localparam int REC1  = (1 << X_W) / L1_LINES;
    localparam int REC2  = (1 << X_W) / L2_LINES;
    localparam int KW    = 2;
    localparam int AW    = tlic_pkg::AGE_W;
    localparam int MW    = ADDR_BITS + AW + 2;
    localparam int V_B   = ADDR_BITS + AW + 1;
    localparam int D_B   = ADDR_BITS + AW;
    localparam int RST_W1 = (2 > MAX_WAYS) ? MAX_WAYS : 2;
    localparam int RST_W2 = (4 > MAX_WAYS) ? MAX_WAYS : 4;

    // memories
    logic [MW-1:0] r_mem1 [L1_LINES];
    logic [MW-1:0] r_mem2 [L2_LINES];
    logic [MW-1:0] r_q1, r_q2;

    // configuration
    logic [3:0] r_blk;
    logic [2:0] r_l1s;
    logic [1:0] r_l1w;
    logic [3:0] r_l2s;
    logic [1:0] r_l2w;
    logic       r_walloc;

    // control
    tlic_pkg::t_state r_state;
    tlic_pkg::t_phase r_phase;
    logic                 r_cmd;
    logic [ADDR_BITS-1:0] r_addr, r_xa;
    logic [RW-1:0]        r_cur, r_slot, r_base, r_rem, r_cc;
    logic [X_W-1:0]       r_x;
    logic [QW-1:0]        r_quo;
    logic [KW-1:0]        r_k;
    logic [AW-1:0]        r_w, r_prev, r_ca1, r_ca2;

    // scan accumulation
    logic          r_fh, r_fhd, r_fi, r_fz;
    logic [RW-1:0] r_fhs, r_fis, r_fzs, r_s0;
    logic [MW-1:0] r_fzw, r_w0;

    // per-level scan results
    logic                 r_hit1, r_hd1, r_vv1, r_vd1, r_hit2, r_vv2;
    logic [RW-1:0]        r_hs1, r_vs1, r_hs2, r_vs2, r_as2;
    logic [ADDR_BITS-1:0] r_vt1, r_vt2;

    // result
    logic r_h1, r_h2, r_wb, r_bi;
    logic r_ov, r_o_h1, r_o_h2, r_o_wb, r_o_bi;

    // phase attributes
    logic is_l2, use_xa, is_scan, is_touch;
    always_comb begin
        is_l2 = !(r_phase == tlic_pkg::PH_L1_LOOK || r_phase == tlic_pkg::PH_L1_HIT_RMW ||
                  r_phase == tlic_pkg::PH_L1_HIT_TCH || r_phase == tlic_pkg::PH_L1_ALLOC_RMW ||
                  r_phase == tlic_pkg::PH_L1_ALLOC_TCH || r_phase == tlic_pkg::PH_BI_SCAN ||
                  r_phase == tlic_pkg::PH_BI_RMW || r_phase == tlic_pkg::PH_BI_TCH);
        use_xa = (r_phase == tlic_pkg::PH_WB_SCAN || r_phase == tlic_pkg::PH_WB_RMW ||
                  r_phase == tlic_pkg::PH_WB_TCH || r_phase == tlic_pkg::PH_BI_SCAN ||
                  r_phase == tlic_pkg::PH_BI_MD_SCAN || r_phase == tlic_pkg::PH_BI_MD_RMW ||
                  r_phase == tlic_pkg::PH_BI_MD_TCH || r_phase == tlic_pkg::PH_BI_RMW ||
                  r_phase == tlic_pkg::PH_BI_TCH);
        is_scan = (r_phase == tlic_pkg::PH_L1_LOOK || r_phase == tlic_pkg::PH_WB_SCAN ||
                   r_phase == tlic_pkg::PH_L2_LOOK || r_phase == tlic_pkg::PH_BI_SCAN ||
                   r_phase == tlic_pkg::PH_BI_MD_SCAN);
        is_touch = (r_phase == tlic_pkg::PH_L1_HIT_TCH || r_phase == tlic_pkg::PH_WB_TCH ||
                    r_phase == tlic_pkg::PH_L1_ALLOC_TCH || r_phase == tlic_pkg::PH_L2_HIT_TCH ||
                    r_phase == tlic_pkg::PH_BI_MD_TCH || r_phase == tlic_pkg::PH_BI_TCH ||
                    r_phase == tlic_pkg::PH_L2_ALLOC_TCH);
    end

    // geometry of the level and address in use
    logic [ADDR_BITS-1:0]          op_a, op_tag, rb_addr, rb_tag, a_sh;
    logic [3:0]                    op_sl;
    logic [1:0]                    op_wl;
    logic [4:0]                    op_pw, op_sh;
    logic [tlic_pkg::WAYS_W-1:0]   op_w;
    logic [AW-1:0]                 op_wm1;
    logic [tlic_pkg::SET_W-1:0]    op_set;
    logic [X_W-1:0]                op_prod;
    logic [QW-1:0]                 op_rec;
    logic [X_W+QW-1:0]             rec_prod;
    logic [RW-1:0]                 op_lines, cur_inc, mod_dif, mod_rem;
    logic                          alloc;

    always_comb begin
        op_a    = use_xa ? r_xa : r_addr;
        op_sl   = is_l2 ? r_l2s : {1'b0, r_l1s};
        op_wl   = is_l2 ? r_l2w : r_l1w;
        op_pw   = 5'd1 << op_wl;
        op_w    = (int'(op_pw) > MAX_WAYS) ? tlic_pkg::WAYS_W'(MAX_WAYS)
                                           : tlic_pkg::WAYS_W'(op_pw);
        op_wm1  = AW'(op_w - 4'd1);
        op_sh   = {1'b0, r_blk} + {1'b0, op_sl};
        a_sh    = op_a >> r_blk;
        op_set  = a_sh[tlic_pkg::SET_W-1:0] & ~({tlic_pkg::SET_W{1'b1}} << op_sl);
        op_tag  = op_a >> op_sh;
        rb_tag  = is_l2 ? r_vt2 : r_vt1;
        rb_addr = (rb_tag << op_sh) | (ADDR_BITS'(op_set) << r_blk);
        op_prod = X_W'(op_set) * X_W'(op_w);
        op_lines = is_l2 ? RW'(L2_LINES) : RW'(L1_LINES);
        op_rec  = is_l2 ? QW'(REC2) : QW'(REC1);
        rec_prod = {{QW{1'b0}}, r_x} * {{X_W{1'b0}}, op_rec};
        cur_inc = (r_cur == op_lines - RW'(1)) ? '0 : r_cur + RW'(1);
        // quotient estimate is exact or one low, so the remainder is below twice the depth
        mod_dif = RW'(r_x) - RW'(r_quo) * op_lines;
        mod_rem = (r_rem >= op_lines) ? r_rem - op_lines : r_rem;
        alloc   = (r_cmd != tlic_pkg::CMD_WRITE) || r_walloc;
    end

    // read data of the level in use
    logic [MW-1:0] q;
    logic          q_v, q_d;
    logic [AW-1:0] q_age;
    logic [ADDR_BITS-1:0] q_tag;
    always_comb begin
        q     = is_l2 ? r_q2 : r_q1;
        q_v   = q[V_B];
        q_d   = q[D_B];
        q_age = q[D_B-1:ADDR_BITS];
        q_tag = q[ADDR_BITS-1:0];
    end

    // memory write port
    logic          we1, we2;
    logic [MW-1:0] wd1, wd2, wd;
    logic [RW-1:0] widx;
    always_comb begin
        wd   = q;
        widx = r_cur;
        we1  = 1'b0;
        we2  = 1'b0;
        case (r_state)
            tlic_pkg::S_TCH_WR0: begin
                wd[D_B-1:ADDR_BITS] = op_wm1;
                we1 = !is_l2;
                we2 = is_l2;
            end
            tlic_pkg::S_TCH_WR: begin
                wd[D_B-1:ADDR_BITS] = q_age - AW'(1);
                if (r_cur != r_slot && q_age > r_prev) begin
                    we1 = !is_l2;
                    we2 = is_l2;
                end
            end
            tlic_pkg::S_RMW_WR: begin
                case (r_phase)
                    tlic_pkg::PH_L1_HIT_RMW, tlic_pkg::PH_L2_HIT_RMW:
                        wd[D_B] = q_d | (r_cmd == tlic_pkg::CMD_WRITE);
                    tlic_pkg::PH_WB_RMW, tlic_pkg::PH_BI_MD_RMW: wd[D_B] = 1'b1;
                    tlic_pkg::PH_BI_RMW: wd[V_B] = 1'b0;
                    default: begin
                        wd[V_B] = 1'b1;
                        wd[D_B] = (r_cmd == tlic_pkg::CMD_WRITE);
                        wd[ADDR_BITS-1:0] = op_tag;
                    end
                endcase
                we1 = !is_l2;
                we2 = is_l2;
            end
            tlic_pkg::S_CLEAR: begin
                widx = r_cc;
                we1  = (r_cc < RW'(L1_LINES));
                we2  = (r_cc < RW'(L2_LINES));
            end
            default: ;
        endcase
        wd1 = (r_state == tlic_pkg::S_CLEAR) ? {2'b00, r_ca1, {ADDR_BITS{1'b0}}} : wd;
        wd2 = (r_state == tlic_pkg::S_CLEAR) ? {2'b00, r_ca2, {ADDR_BITS{1'b0}}} : wd;
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_mem1[widx[IW1-1:0]] <= wd1;
        end
        if (we2) begin
            r_mem2[widx[IW2-1:0]] <= wd2;
        end
        r_q1 <= r_mem1[r_cur[IW1-1:0]];
        r_q2 <= r_mem2[r_cur[IW2-1:0]];
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk    <= tlic_pkg::RST_BLOCK_LOG2;
            r_l1s    <= tlic_pkg::RST_L1_SETS_LOG2;
            r_l1w    <= tlic_pkg::RST_L1_WAYS_LOG2;
            r_l2s    <= tlic_pkg::RST_L2_SETS_LOG2;
            r_l2w    <= tlic_pkg::RST_L2_WAYS_LOG2;
            r_walloc <= tlic_pkg::RST_WRITE_ALLOC;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tlic_pkg::CFG_BLOCK_LOG2:   r_blk    <= i_cfg_data;
                tlic_pkg::CFG_L1_SETS_LOG2: r_l1s    <= i_cfg_data[2:0];
                tlic_pkg::CFG_L1_WAYS_LOG2: r_l1w    <= i_cfg_data[1:0];
                tlic_pkg::CFG_L2_SETS_LOG2: r_l2s    <= i_cfg_data;
                tlic_pkg::CFG_L2_WAYS_LOG2: r_l2w    <= i_cfg_data[1:0];
                tlic_pkg::CFG_WRITE_ALLOC:  r_walloc <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlic_pkg::S_CLEAR;
            r_phase <= tlic_pkg::PH_DONE;
            r_cc    <= '0;
            r_ca1   <= '0;
            r_ca2   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (!i_out_stall && r_state != tlic_pkg::S_FIN) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                tlic_pkg::S_CLEAR: begin
                    r_cc  <= r_cc + RW'(1);
                    r_ca1 <= (r_ca1 == AW'(RST_W1 - 1)) ? '0 : r_ca1 + AW'(1);
                    r_ca2 <= (r_ca2 == AW'(RST_W2 - 1)) ? '0 : r_ca2 + AW'(1);
                    if (r_cc == RW'(MAXL - 1)) begin
                        r_state <= tlic_pkg::S_IDLE;
                    end
                end
                tlic_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_command;
                        r_addr  <= i_address;
                        r_h1    <= 1'b0;
                        r_h2    <= 1'b0;
                        r_wb    <= 1'b0;
                        r_bi    <= 1'b0;
                        r_phase <= tlic_pkg::PH_L1_LOOK;
                        r_state <= tlic_pkg::S_LAUNCH;
                    end
                end
                tlic_pkg::S_LAUNCH: begin
                    if (r_phase == tlic_pkg::PH_DONE) begin
                        r_state <= tlic_pkg::S_FIN;
                    end else if (is_scan || is_touch) begin
                        r_state <= tlic_pkg::S_MUL;
                    end else begin
                        case (r_phase)
                            tlic_pkg::PH_L1_HIT_RMW, tlic_pkg::PH_BI_RMW: begin
                                r_cur <= r_hs1; r_slot <= r_hs1;
                            end
                            tlic_pkg::PH_L1_ALLOC_RMW: begin
                                r_cur <= r_vs1; r_slot <= r_vs1;
                            end
                            tlic_pkg::PH_L2_ALLOC_RMW: begin
                                r_cur <= r_as2; r_slot <= r_as2;
                            end
                            default: begin
                                r_cur <= r_hs2; r_slot <= r_hs2;
                            end
                        endcase
                        r_state <= tlic_pkg::S_RMW_RD;
                    end
                end
                tlic_pkg::S_MUL: begin
                    r_x     <= op_prod;
                    r_k     <= '0;
                    r_rem   <= '0;
                    r_state <= tlic_pkg::S_MOD;
                end
                tlic_pkg::S_MOD: begin
                    // set*ways modulo the store depth: reciprocal estimate, then one correction
                    r_k <= r_k + KW'(1);
                    if (r_k == KW'(0)) begin
                        r_quo <= rec_prod[X_W+QW-1:X_W];
                    end else if (r_k == KW'(1)) begin
                        r_rem <= mod_dif;
                    end else begin
                        r_base <= mod_rem;
                        r_w    <= '0;
                        if (is_scan) begin
                            r_cur   <= mod_rem;
                            r_fh    <= 1'b0;
                            r_fi    <= 1'b0;
                            r_fz    <= 1'b0;
                            r_state <= tlic_pkg::S_SCAN_RD;
                        end else begin
                            r_cur   <= r_slot;
                            r_state <= tlic_pkg::S_TCH_RD0;
                        end
                    end
                end
                tlic_pkg::S_SCAN_RD: r_state <= tlic_pkg::S_SCAN_CK;
                tlic_pkg::S_SCAN_CK: begin
                    if (q_v && q_tag == op_tag && !r_fh) begin
                        r_fh  <= 1'b1;
                        r_fhs <= r_cur;
                        r_fhd <= q_d;
                    end
                    if (!q_v && !r_fi) begin
                        r_fi  <= 1'b1;
                        r_fis <= r_cur;
                    end
                    if (q_age == '0 && !r_fz) begin
                        r_fz  <= 1'b1;
                        r_fzs <= r_cur;
                        r_fzw <= q;
                    end
                    if (r_w == '0) begin
                        r_s0 <= r_cur;
                        r_w0 <= q;
                    end
                    if (r_w == op_wm1) begin
                        r_state <= tlic_pkg::S_SCAN_END;
                    end else begin
                        r_w     <= r_w + AW'(1);
                        r_cur   <= cur_inc;
                        r_state <= tlic_pkg::S_SCAN_RD;
                    end
                end
                tlic_pkg::S_SCAN_END: begin
                    // victim: first invalid way, else first age zero, else way zero
                    if (is_l2) begin
                        r_hit2 <= r_fh;
                        r_hs2  <= r_fhs;
                        r_vs2  <= r_fi ? r_fis : (r_fz ? r_fzs : r_s0);
                        r_vv2  <= !r_fi;
                        r_vt2  <= r_fz ? r_fzw[ADDR_BITS-1:0] : r_w0[ADDR_BITS-1:0];
                    end else begin
                        r_hit1 <= r_fh;
                        r_hs1  <= r_fhs;
                        r_hd1  <= r_fhd;
                        r_vs1  <= r_fi ? r_fis : (r_fz ? r_fzs : r_s0);
                        r_vv1  <= !r_fi;
                        r_vd1  <= r_fz ? r_fzw[D_B] : r_w0[D_B];
                        r_vt1  <= r_fz ? r_fzw[ADDR_BITS-1:0] : r_w0[ADDR_BITS-1:0];
                    end
                    r_state <= tlic_pkg::S_NEXT;
                end
                tlic_pkg::S_TCH_RD0: r_state <= tlic_pkg::S_TCH_WR0;
                tlic_pkg::S_TCH_WR0: begin
                    r_prev  <= q_age;
                    r_cur   <= r_base;
                    r_state <= tlic_pkg::S_TCH_RD;
                end
                tlic_pkg::S_TCH_RD: r_state <= tlic_pkg::S_TCH_WR;
                tlic_pkg::S_TCH_WR: begin
                    if (r_w == op_wm1) begin
                        r_state <= tlic_pkg::S_NEXT;
                    end else begin
                        r_w     <= r_w + AW'(1);
                        r_cur   <= cur_inc;
                        r_state <= tlic_pkg::S_TCH_RD;
                    end
                end
                tlic_pkg::S_RMW_RD: r_state <= tlic_pkg::S_RMW_WR;
                tlic_pkg::S_RMW_WR: r_state <= tlic_pkg::S_NEXT;
                tlic_pkg::S_NEXT: begin
                    r_state <= tlic_pkg::S_LAUNCH;
                    case (r_phase)
                        tlic_pkg::PH_L1_LOOK: begin
                            r_h1 <= r_hit1;
                            if (r_hit1) begin
                                r_phase <= tlic_pkg::PH_L1_HIT_RMW;
                            end else if (alloc) begin
                                r_xa <= rb_addr;
                                r_phase <= (r_vv1 && r_vd1) ? tlic_pkg::PH_WB_SCAN
                                                            : tlic_pkg::PH_L1_ALLOC_RMW;
                            end else begin
                                r_phase <= tlic_pkg::PH_L2_LOOK;
                            end
                        end
                        tlic_pkg::PH_L1_HIT_RMW:   r_phase <= tlic_pkg::PH_L1_HIT_TCH;
                        tlic_pkg::PH_L1_HIT_TCH:   r_phase <= tlic_pkg::PH_DONE;
                        tlic_pkg::PH_WB_SCAN: begin
                            r_wb    <= r_hit2;
                            r_phase <= r_hit2 ? tlic_pkg::PH_WB_RMW
                                              : tlic_pkg::PH_L1_ALLOC_RMW;
                        end
                        tlic_pkg::PH_WB_RMW:       r_phase <= tlic_pkg::PH_WB_TCH;
                        tlic_pkg::PH_WB_TCH:       r_phase <= tlic_pkg::PH_L1_ALLOC_RMW;
                        tlic_pkg::PH_L1_ALLOC_RMW: r_phase <= tlic_pkg::PH_L1_ALLOC_TCH;
                        tlic_pkg::PH_L1_ALLOC_TCH: r_phase <= tlic_pkg::PH_L2_LOOK;
                        tlic_pkg::PH_L2_LOOK: begin
                            r_h2  <= r_hit2;
                            r_as2 <= r_vs2;
                            if (r_hit2) begin
                                r_phase <= tlic_pkg::PH_L2_HIT_RMW;
                            end else if (alloc) begin
                                r_xa    <= rb_addr;
                                r_phase <= r_vv2 ? tlic_pkg::PH_BI_SCAN
                                                 : tlic_pkg::PH_L2_ALLOC_RMW;
                            end else begin
                                r_phase <= tlic_pkg::PH_DONE;
                            end
                        end
                        tlic_pkg::PH_L2_HIT_RMW:   r_phase <= tlic_pkg::PH_L2_HIT_TCH;
                        tlic_pkg::PH_L2_HIT_TCH:   r_phase <= tlic_pkg::PH_DONE;
                        tlic_pkg::PH_BI_SCAN: begin
                            r_bi <= r_hit1;
                            if (!r_hit1) begin
                                r_phase <= tlic_pkg::PH_L2_ALLOC_RMW;
                            end else begin
                                r_phase <= r_hd1 ? tlic_pkg::PH_BI_MD_SCAN
                                                 : tlic_pkg::PH_BI_RMW;
                            end
                        end
                        tlic_pkg::PH_BI_MD_SCAN:
                            r_phase <= r_hit2 ? tlic_pkg::PH_BI_MD_RMW : tlic_pkg::PH_BI_RMW;
                        tlic_pkg::PH_BI_MD_RMW:    r_phase <= tlic_pkg::PH_BI_MD_TCH;
                        tlic_pkg::PH_BI_MD_TCH:    r_phase <= tlic_pkg::PH_BI_RMW;
                        tlic_pkg::PH_BI_RMW:       r_phase <= tlic_pkg::PH_BI_TCH;
                        tlic_pkg::PH_BI_TCH:       r_phase <= tlic_pkg::PH_L2_ALLOC_RMW;
                        tlic_pkg::PH_L2_ALLOC_RMW: r_phase <= tlic_pkg::PH_L2_ALLOC_TCH;
                        default:                   r_phase <= tlic_pkg::PH_DONE;
                    endcase
                end
                tlic_pkg::S_FIN: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov    <= 1'b1;
                        r_o_h1  <= r_h1;
                        r_o_h2  <= r_h2;
                        r_o_wb  <= r_wb;
                        r_o_bi  <= r_bi;
                        r_state <= tlic_pkg::S_IDLE;
                    end
                end
                default: r_state <= tlic_pkg::S_IDLE;
            endcase
        end
    end

    assign o_in_stall           = (r_state != tlic_pkg::S_IDLE);
    assign o_out_valid          = r_ov;
    assign o_l1_hit             = r_o_h1;
    assign o_l2_hit             = r_o_h2;
    assign o_l1_writeback       = r_o_wb;
    assign o_l2_back_invalidate = r_o_bi;

    `TLIC_ASSERT_NOW(a_hit_excl, o_out_valid, !(o_l1_hit && (o_l2_hit || o_l1_writeback || o_l2_back_invalidate)), "l1 hit reported with miss events")
    `TLIC_ASSERT_NOW(a_bi_miss, o_out_valid && o_l2_back_invalidate, !o_l2_hit, "back-invalidate on an l2 hit")
    `TLIC_ASSERT_NEXT(a_result_src, !o_out_valid && r_state != tlic_pkg::S_FIN, !o_out_valid, "result without finished request")

endmodule

// ===== test/tb_two_level_inclusive_lru_cache.sv =====
// ---------------------------------------------------------------------------
// tb_two_level_inclusive_lru_cache
// Self-checking bench for the inclusive two-level tag cache. Requests are
// queued per phase, driven under several idle/stall patterns and geometry
// settings, and every result is checked against an in-bench cache model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_level_inclusive_lru_cache;

    localparam logic CMD_READ   = ~tlic_pkg::CMD_WRITE;
    localparam int   LIMIT_CYC  = 1000000;
    localparam int   LVL_LINES [2] = '{tlic_pkg::DEF_L1_LINES, tlic_pkg::DEF_L2_LINES};

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic        cmd;
        logic [31:0] addr;
    } t_access;

    typedef struct {
        bit l1_hit;
        bit l2_hit;
        bit l1_writeback;
        bit l2_back_invalidate;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command = 1'b0;
    logic [31:0] i_address = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_l1_hit;
    logic        o_l2_hit;
    logic        o_l1_writeback;
    logic        o_l2_back_invalidate;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [tlic_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tlic_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    two_level_inclusive_lru_cache u_dut (.*);

    always #10 i_clk = ~i_clk;

    // cache model state, index 0 is L1 and 1 is L2
    logic [31:0] mdl_tag   [2][tlic_pkg::DEF_L2_LINES];
    bit          mdl_valid [2][tlic_pkg::DEF_L2_LINES];
    bit          mdl_dirty [2][tlic_pkg::DEF_L2_LINES];
    logic [2:0]  mdl_age   [2][tlic_pkg::DEF_L2_LINES];
    int unsigned blk_lg;
    int unsigned sets_lg [2];
    int unsigned ways_lg [2];
    bit          wr_alloc;

    t_access    req_q[$];
    t_outcome   outcome_q[$];
    t_idle_mode idle_mode = IDLE_NONE;
    int         errors = 0;
    int         cycles = 0;
    int         n_req = 0, n_l1 = 0, n_l2 = 0, n_wb = 0, n_bi = 0;

    function automatic int unsigned ways_of(int lv);
        int unsigned w;
        w = 1 << ways_lg[lv];
        return (w > tlic_pkg::DEF_MAX_WAYS) ? tlic_pkg::DEF_MAX_WAYS : w;
    endfunction

    function automatic int unsigned slot(int lv, int unsigned set, int unsigned w);
        return (set * ways_of(lv) + w) % LVL_LINES[lv];
    endfunction

    function automatic int unsigned set_of(int lv, logic [31:0] a);
        return (a >> blk_lg) & ((32'd1 << sets_lg[lv]) - 1);
    endfunction

    function automatic logic [31:0] tag_of(int lv, logic [31:0] a);
        return a >> (blk_lg + sets_lg[lv]);
    endfunction

    function automatic logic [31:0] addr_of(int lv, int unsigned set, logic [31:0] tag);
        logic [63:0] a;
        a = ({32'd0, tag} << (blk_lg + sets_lg[lv])) | (64'(set) << blk_lg);
        return a[31:0];
    endfunction

    function automatic int find_way(int lv, int unsigned set, logic [31:0] tag);
        int unsigned i;
        for (int unsigned w = 0; w < ways_of(lv); w++) begin
            i = slot(lv, set, w);
            if (mdl_valid[lv][i] && mdl_tag[lv][i] == tag)
                return w;
        end
        return -1;
    endfunction

    function automatic void touch(int lv, int unsigned set, int unsigned way);
        int unsigned t, i;
        logic [2:0] prev;
        t = slot(lv, set, way);
        prev = mdl_age[lv][t];
        mdl_age[lv][t] = 3'(ways_of(lv) - 1);
        for (int unsigned w = 0; w < ways_of(lv); w++) begin
            i = slot(lv, set, w);
            if (i != t && mdl_age[lv][i] > prev)
                mdl_age[lv][i]--;
        end
    endfunction

    function automatic int unsigned pick_victim(int lv, int unsigned set);
        for (int unsigned w = 0; w < ways_of(lv); w++)
            if (!mdl_valid[lv][slot(lv, set, w)])
                return w;
        for (int unsigned w = 0; w < ways_of(lv); w++)
            if (mdl_age[lv][slot(lv, set, w)] == 0)
                return w;
        return 0;
    endfunction

    function automatic bit mark_l2_dirty(logic [31:0] a);
        int unsigned s;
        int w;
        s = set_of(1, a);
        w = find_way(1, s, tag_of(1, a));
        if (w < 0)
            return 0;
        mdl_dirty[1][slot(1, s, w)] = 1;
        touch(1, s, w);
        return 1;
    endfunction

    function automatic int unsigned fill_l1(int unsigned set, logic [31:0] tag,
                                            inout bit wb);
        int unsigned w, i;
        w = pick_victim(0, set);
        i = slot(0, set, w);
        if (mdl_valid[0][i] && mdl_dirty[0][i])
            wb = mark_l2_dirty(addr_of(0, set, mdl_tag[0][i]));
        mdl_valid[0][i] = 1;
        mdl_dirty[0][i] = 0;
        mdl_tag[0][i] = tag;
        touch(0, set, w);
        return i;
    endfunction

    function automatic int unsigned fill_l2(int unsigned set, logic [31:0] tag,
                                            inout bit bi);
        int unsigned w, i, s1, j;
        int w1;
        logic [31:0] a;
        w = pick_victim(1, set);
        i = slot(1, set, w);
        if (mdl_valid[1][i]) begin
            // inclusion: the evicted L2 line leaves L1 too
            a = addr_of(1, set, mdl_tag[1][i]);
            s1 = set_of(0, a);
            w1 = find_way(0, s1, tag_of(0, a));
            if (w1 >= 0) begin
                j = slot(0, s1, w1);
                if (mdl_dirty[0][j])
                    void'(mark_l2_dirty(a));
                mdl_valid[0][j] = 0;
                touch(0, s1, w1);
                bi = 1;
            end
        end
        mdl_valid[1][i] = 1;
        mdl_dirty[1][i] = 0;
        mdl_tag[1][i] = tag;
        touch(1, set, w);
        return i;
    endfunction

    function automatic t_outcome predict_access(logic cmd, logic [31:0] a);
        t_outcome r;
        bit wr, alloc;
        int unsigned s1, s2, i;
        logic [31:0] t1, t2;
        int w1, w2;
        r = '{0, 0, 0, 0};
        wr = (cmd == tlic_pkg::CMD_WRITE);
        alloc = !wr || wr_alloc;
        s1 = set_of(0, a);
        t1 = tag_of(0, a);
        w1 = find_way(0, s1, t1);
        if (w1 >= 0) begin
            r.l1_hit = 1;
            if (wr)
                mdl_dirty[0][slot(0, s1, w1)] = 1;
            touch(0, s1, w1);
        end else begin
            if (alloc) begin
                i = fill_l1(s1, t1, r.l1_writeback);
                if (wr)
                    mdl_dirty[0][i] = 1;
            end
            s2 = set_of(1, a);
            t2 = tag_of(1, a);
            w2 = find_way(1, s2, t2);
            if (w2 >= 0) begin
                r.l2_hit = 1;
                if (wr)
                    mdl_dirty[1][slot(1, s2, w2)] = 1;
                touch(1, s2, w2);
            end else if (alloc) begin
                i = fill_l2(s2, t2, r.l2_back_invalidate);
                if (wr)
                    mdl_dirty[1][i] = 1;
            end
        end
        return r;
    endfunction

    function automatic int src_idle_pct();
        return (idle_mode == IDLE_SRC) ? 85 : (idle_mode == IDLE_BOTH) ? 33 : 0;
    endfunction

    function automatic int snk_stall_pct();
        return (idle_mode == IDLE_SNK) ? 85 : (idle_mode == IDLE_BOTH) ? 33 : 0;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_access  r;
        t_outcome e;
        bit       fire;
        if (i_rst_n) begin
            fire = i_in_valid && !o_in_stall;
            if (fire) begin
                e = predict_access(i_command, i_address);
                outcome_q.push_back(e);
                n_req++;
                n_l1 += e.l1_hit;
                n_l2 += e.l2_hit;
                n_wb += e.l1_writeback;
                n_bi += e.l2_back_invalidate;
            end
            if (fire || !i_in_valid) begin
                if (req_q.size() > 0 && $urandom_range(99) >= src_idle_pct()) begin
                    r = req_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_command  <= r.cmd;
                    i_address  <= r.addr;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    e = outcome_q.pop_front();
                    if (o_l1_hit !== e.l1_hit) begin
                        $error("l1_hit: expected %0d, got %0b", e.l1_hit, o_l1_hit);
                        errors++;
                    end
                    if (o_l2_hit !== e.l2_hit) begin
                        $error("l2_hit: expected %0d, got %0b", e.l2_hit, o_l2_hit);
                        errors++;
                    end
                    if (o_l1_writeback !== e.l1_writeback) begin
                        $error("l1_writeback: expected %0d, got %0b",
                               e.l1_writeback, o_l1_writeback);
                        errors++;
                    end
                    if (o_l2_back_invalidate !== e.l2_back_invalidate) begin
                        $error("l2_back_invalidate: expected %0d, got %0b",
                               e.l2_back_invalidate, o_l2_back_invalidate);
                        errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < snk_stall_pct());
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYC) begin
            $display("timeout with %0d results outstanding", outcome_q.size());
            $display("tb_two_level_inclusive_lru_cache: FAIL");
            $finish;
        end
    end

    // starts right after a rising edge, leaves valid high for the next write
    task automatic cfg_write(logic [tlic_pkg::CFG_IDX_W-1:0] idx,
                             logic [tlic_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            tlic_pkg::CFG_BLOCK_LOG2:   blk_lg = val;
            tlic_pkg::CFG_L1_SETS_LOG2: sets_lg[0] = val[2:0];
            tlic_pkg::CFG_L1_WAYS_LOG2: ways_lg[0] = val[1:0];
            tlic_pkg::CFG_L2_SETS_LOG2: sets_lg[1] = val;
            tlic_pkg::CFG_L2_WAYS_LOG2: ways_lg[1] = val[1:0];
            tlic_pkg::CFG_WRITE_ALLOC:  wr_alloc = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(int blk, int s1, int w1, int s2, int w2, int wa);
        @(posedge i_clk);
        cfg_write(tlic_pkg::CFG_BLOCK_LOG2, tlic_pkg::CFG_DATA_W'(blk));
        cfg_write(tlic_pkg::CFG_L1_SETS_LOG2, tlic_pkg::CFG_DATA_W'(s1));
        cfg_write(tlic_pkg::CFG_L1_WAYS_LOG2, tlic_pkg::CFG_DATA_W'(w1));
        cfg_write(tlic_pkg::CFG_L2_SETS_LOG2, tlic_pkg::CFG_DATA_W'(s2));
        cfg_write(tlic_pkg::CFG_L2_WAYS_LOG2, tlic_pkg::CFG_DATA_W'(w2));
        cfg_write(tlic_pkg::CFG_WRITE_ALLOC, tlic_pkg::CFG_DATA_W'(wa));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_req(logic cmd, logic [31:0] a);
        t_access r;
        r.cmd = cmd;
        r.addr = a;
        req_q.push_back(r);
    endtask

    // mostly reuse of a small address pool so lines hit, conflict and evict
    task automatic add_random(int n);
        logic [31:0] pool [12];
        logic [31:0] a;
        int k;
        foreach (pool[p])
            pool[p] = $urandom();
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(99);
            a = pool[$urandom_range(11)];
            if (k >= 85)
                a = $urandom();
            else if (k >= 55)
                a = a ^ ($urandom() << $urandom_range(4, 20));
            add_req($urandom_range(1) ? tlic_pkg::CMD_WRITE : CMD_READ, a);
        end
    endtask

    task automatic drain(int tail);
        while (req_q.size() > 0 || i_in_valid || outcome_q.size() > 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    initial begin
        blk_lg = tlic_pkg::RST_BLOCK_LOG2;
        sets_lg[0] = tlic_pkg::RST_L1_SETS_LOG2;
        ways_lg[0] = tlic_pkg::RST_L1_WAYS_LOG2;
        sets_lg[1] = tlic_pkg::RST_L2_SETS_LOG2;
        ways_lg[1] = tlic_pkg::RST_L2_WAYS_LOG2;
        wr_alloc = tlic_pkg::RST_WRITE_ALLOC;
        for (int lv = 0; lv < 2; lv++)
            for (int i = 0; i < tlic_pkg::DEF_L2_LINES; i++) begin
                mdl_tag[lv][i] = '0;
                mdl_valid[lv][i] = 0;
                mdl_dirty[lv][i] = 0;
                mdl_age[lv][i] = 3'(i % ways_of(lv));
            end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: fill, hit, dirty, evict with write-back, L2 refetch
        add_req(CMD_READ, 32'h0000_0000);
        add_req(CMD_READ, 32'h0000_0000);
        add_req(tlic_pkg::CMD_WRITE, 32'h0000_0000);
        add_req(CMD_READ, 32'hFFFF_FFFF);
        add_req(tlic_pkg::CMD_WRITE, 32'hFFFF_FFFC);
        add_req(CMD_READ, 32'h0000_0020);
        add_req(CMD_READ, 32'h0000_0040);
        add_req(CMD_READ, 32'h0000_0000);
        for (int j = 1; j <= 6; j++)
            add_req(j[0] ? tlic_pkg::CMD_WRITE : CMD_READ, 32'h100 * j);
        add_req(tlic_pkg::CMD_WRITE, 32'hAAAA_AAAA);
        add_req(tlic_pkg::CMD_WRITE, 32'h5555_5555);
        add_req(CMD_READ, 32'h8000_0000);
        add_random(60);
        drain(20);

        // smallest geometry, write-around
        idle_mode = IDLE_SRC;
        configure(0, 0, 0, 0, 0, 0);
        add_req(tlic_pkg::CMD_WRITE, 32'h0000_1234);
        add_req(CMD_READ, 32'h0000_1234);
        add_req(tlic_pkg::CMD_WRITE, 32'h0000_1234);
        add_req(CMD_READ, 32'h0000_5678);
        add_random(60);
        drain(20);

        // largest geometry of the bench
        idle_mode = IDLE_SNK;
        configure(8, 6, 3, 10, 3, 1);
        add_random(80);
        drain(20);

        idle_mode = IDLE_BOTH;
        configure(4, 2, 2, 3, 1, 1);
        add_random(100);
        drain(20);

        // L2 smaller than L1 reach: frequent back-invalidation
        idle_mode = IDLE_NONE;
        configure(6, 1, 3, 2, 0, 0);
        add_random(50);
        drain(20);
        configure(1, 3, 1, 1, 0, 1);
        add_random(50);
        drain(50);

        $display("%0d requests checked over 6 geometries and 4 handshake patterns",
                 n_req);
        $display("events: %0d L1 hits, %0d L2 hits, %0d write-backs, %0d back-invalidates",
                 n_l1, n_l2, n_wb, n_bi);
        if (errors == 0) begin
            $display("tb_two_level_inclusive_lru_cache: PASS");
        end else begin
            $display("tb_two_level_inclusive_lru_cache: FAIL");
        end
        $finish;
    end

endmodule

// ===== two_level_inclusive_lru_cache.f =====
+incdir+rtl
rtl/tlic_pkg.sv
rtl/two_level_inclusive_lru_cache.sv
test/tb_two_level_inclusive_lru_cache.sv
